// File: rtl/core/csm_pkg.sv
// shared widths and the classified segment record for the colinear segment merger
// no dependencies; compiled first

package csm_pkg;

	// field widths
	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int RAD_W   = 31;
	localparam int DEPTH_W = 8;
	localparam int PAR_W   = 11;
	localparam int PIDX_W  = 10;
	localparam int EPS_W   = 31;
	localparam int THR_W   = 16;

	// shared multiplier and accumulator widths
	localparam int MUL_W  = 35;
	localparam int PROD_W = 70;
	localparam int ACC_W  = 170;

	// segment after the front end: coordinates, direction, decoded parent
	typedef struct packed {
		logic [2:0][COORD_W-1:0] s;
		logic [2:0][COORD_W-1:0] e;
		logic [2:0][DIFF_W-1:0]  cv;
		logic [RAD_W-1:0]        sr;
		logic [RAD_W-1:0]        er;
		logic [DEPTH_W-1:0]      depth;
		logic                    par_ok;
		logic [PIDX_W-1:0]       par_idx;
		logic                    last;
	} seg_item_t;

endpackage

// File: rtl/core/csm_if.sv
// request channels of the colinear segment merger: input segments and merged segments
// depends on csm_pkg for field widths

interface csm_seg_if;
	import csm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] start_z;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;
	logic signed [COORD_W-1:0] end_z;
	logic [RAD_W-1:0]          start_radius;
	logic [RAD_W-1:0]          end_radius;
	logic [DEPTH_W-1:0]        branch_depth;
	logic signed [PAR_W-1:0]   parent_in;
	logic                      final_in;

	modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		start_radius, end_radius, branch_depth, parent_in, final_in, input ready);
	modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
		start_radius, end_radius, branch_depth, parent_in, final_in, output ready);
endinterface

interface csm_merged_if;
	import csm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] out_start_x;
	logic signed [COORD_W-1:0] out_start_y;
	logic signed [COORD_W-1:0] out_start_z;
	logic signed [COORD_W-1:0] out_end_x;
	logic signed [COORD_W-1:0] out_end_y;
	logic signed [COORD_W-1:0] out_end_z;
	logic [RAD_W-1:0]          out_start_radius;
	logic [RAD_W-1:0]          out_end_radius;
	logic [DEPTH_W-1:0]        out_depth;
	logic signed [PAR_W-1:0]   out_parent;
	logic                      out_last;

	modport source (output valid, out_start_x, out_start_y, out_start_z, out_end_x,
		out_end_y, out_end_z, out_start_radius, out_end_radius, out_depth, out_parent,
		out_last, input ready);
	modport sink (input valid, out_start_x, out_start_y, out_start_z, out_end_x,
		out_end_y, out_end_z, out_start_radius, out_end_radius, out_depth, out_parent,
		out_last, output ready);
endinterface

// File: rtl/core/csm_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module csm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/csm_front.sv
// front end: takes input segment requests, forms the direction vector, decodes the parent
// depends on csm_pkg and csm_if

module csm_front #(
	parameter int MAX_SEGMENTS = 1024
) (
	csm_seg_if.sink              seg,
	input  logic                 room,
	output logic                 push,
	output csm_pkg::seg_item_t   item
);
	import csm_pkg::*;

	// request taken whenever the queue has room
	assign seg.ready = room;
	assign push      = seg.valid && room;

	// classify the segment
	always_comb begin
		item.s[0]    = seg.start_x;
		item.s[1]    = seg.start_y;
		item.s[2]    = seg.start_z;
		item.e[0]    = seg.end_x;
		item.e[1]    = seg.end_y;
		item.e[2]    = seg.end_z;
		item.cv[0]   = DIFF_W'(seg.end_x) - DIFF_W'(seg.start_x);
		item.cv[1]   = DIFF_W'(seg.end_y) - DIFF_W'(seg.start_y);
		item.cv[2]   = DIFF_W'(seg.end_z) - DIFF_W'(seg.start_z);
		item.sr      = seg.start_radius;
		item.er      = seg.end_radius;
		item.depth   = seg.branch_depth;
		// negative parent or one at or beyond the table size means no parent
		item.par_idx = seg.parent_in[PIDX_W-1:0];
		item.par_ok  = !seg.parent_in[PAR_W-1] &&
			(32'(seg.parent_in[PIDX_W-1:0]) < 32'(MAX_SEGMENTS));
		item.last    = seg.final_in;
	end

endmodule

// File: rtl/core/csm_queue.sv
// two entry queue between the front end and the merge engine
// depends on csm_pkg for the segment record

module csm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csm_pkg::seg_item_t din,
	output logic               room,
	input  logic               pop,
	output csm_pkg::seg_item_t dout,
	output logic               avail
);
	import csm_pkg::*;

	seg_item_t  mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign room  = (cnt_q != 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign dout  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// File: rtl/core/csm_back.sv
// merge engine: remap table, serial merge test on a shared multiplier, pending segment
// depends on csm_pkg, csm_if and csm_ram

module csm_back #(
	parameter int MAX_SEGMENTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  csm_pkg::seg_item_t          item,
	input  logic                        avail,
	output logic                        pop,
	input  logic [csm_pkg::EPS_W-1:0]   eps,
	input  logic [csm_pkg::THR_W-1:0]   thr,
	csm_merged_if.source                merged
);
	import csm_pkg::*;

	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam logic [4:0] LAST_ISSUE = 5'd25;
	localparam logic [4:0] LAST_STEP  = 5'd27;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_CALC, S_DECIDE, S_LAST} state_t;
	typedef enum logic [3:0] {
		ACC_G, ACC_LP, ACC_LC, ACC_DOT, ACC_E, ACC_T, ACC_M, ACC_L, ACC_R
	} acc_sel_t;
	localparam int ACC_N = 9;

	typedef struct packed {
		logic             en;
		acc_sel_t         dst;
		logic [1:0]       sh;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_op_t;

	state_t             state_q;
	logic [4:0]         step_q;
	logic               merge_q;
	logic               pend_valid_q;
	logic [IDX_W-1:0]   in_cnt_q;
	logic [IDX_W-1:0]   out_cnt_q;
	logic               out_valid_q;

	seg_item_t               item_q;
	logic [PAR_W-1:0]        rp_q;
	logic [2:0][COORD_W-1:0] pend_s_q;
	logic [2:0][COORD_W-1:0] pend_e_q;
	logic [RAD_W-1:0]        pend_sr_q;
	logic [RAD_W-1:0]        pend_er_q;
	logic [DEPTH_W-1:0]      pend_depth_q;
	logic [PAR_W-1:0]        pend_par_q;
	logic [2:0][COORD_W-1:0] out_s_q;
	logic [2:0][COORD_W-1:0] out_e_q;
	logic [RAD_W-1:0]        out_sr_q;
	logic [RAD_W-1:0]        out_er_q;
	logic [DEPTH_W-1:0]      out_depth_q;
	logic [PAR_W-1:0]        out_par_q;
	logic                    out_last_q;

	logic [ACC_W-1:0]         acc_q [ACC_N];
	logic signed [PROD_W-1:0] p_s1;
	logic                     en_s1;
	acc_sel_t                 dst_s1;
	logic [1:0]               sh_s1;

	logic [2:0][DIFF_W-1:0] gap;
	logic [2:0][DIFF_W-1:0] pv;
	logic [67:0]            lp_v;
	logic [67:0]            lc_v;
	logic [67:0]            dabs_v;
	logic [ACC_W-1:0]       dabs_w;
	logic [135:0]           m_v;
	logic [31:0]            t_v;
	mul_op_t                op;
	logic [ACC_W-1:0]       base;
	logic [ACC_W-1:0]       addend;

	logic [IDX_W-1:0] ram_raddr;
	logic [IDX_W-1:0] ram_rdata;
	logic [IDX_W-1:0] ram_wdata;
	logic             ram_we;
	logic [31:0]      par32;
	logic [31:0]      rd32;
	logic [PAR_W-1:0] rp_d;
	logic             cand_d;

	logic             gap_ok;
	logic             nz;
	logic [ACC_W-1:0] lhs;
	logic             merge_d;

	logic             out_free;
	logic             decide_go;
	logic             emit_mid;
	logic             emit_last;
	logic             take_new;
	logic             ext_end;
	logic [IDX_W-1:0] oc_inc;
	logic [IDX_W-1:0] oc_new;
	logic [IDX_W-1:0] ic_inc;

	function automatic logic [IDX_W-1:0] next_count(input logic [IDX_W-1:0] c);
		logic [31:0] n;
		logic [IDX_W-1:0] r;
		n = 32'(c) + 32'd1;
		if (n >= 32'(MAX_SEGMENTS)) begin
			r = '0;
		end else begin
			r = n[IDX_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [MUL_W-1:0] sx(input logic [DIFF_W-1:0] d);
		return MUL_W'($signed(d));
	endfunction

	function automatic logic [MUL_W-1:0] z34(input logic [33:0] x);
		return {1'b0, x};
	endfunction

	// remap table, indexed by input count
	assign par32     = 32'(item.par_idx);
	assign ram_raddr = par32[IDX_W-1:0];

	csm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SEGMENTS)) u_remap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_cnt_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// remapped parent and merge candidate
	assign rd32   = 32'(ram_rdata);
	assign rp_d   = item_q.par_ok ? rd32[PAR_W-1:0] : '1;
	assign cand_d = pend_valid_q && item_q.par_ok && (ram_rdata == out_cnt_q);

	// gap and pending direction
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			gap[k] = DIFF_W'($signed(item_q.s[k])) - DIFF_W'($signed(pend_e_q[k]));
			pv[k]  = DIFF_W'($signed(pend_e_q[k])) - DIFF_W'($signed(pend_s_q[k]));
		end
	end

	// operands taken from finished sums
	assign lp_v   = acc_q[ACC_LP][67:0];
	assign lc_v   = acc_q[ACC_LC][67:0];
	assign dabs_w = acc_q[ACC_DOT][ACC_W-1] ? (~acc_q[ACC_DOT] + 1'b1) : acc_q[ACC_DOT];
	assign dabs_v = dabs_w[67:0];
	assign m_v    = acc_q[ACC_M][135:0];
	assign t_v    = acc_q[ACC_T][31:0];

	// product schedule of the merge test
	always_comb begin
		op = '0;
		case (step_q)
			5'd0:  begin op.a = sx(gap[0]); op.b = sx(gap[0]); op.dst = ACC_G; end
			5'd1:  begin op.a = sx(gap[1]); op.b = sx(gap[1]); op.dst = ACC_G; end
			5'd2:  begin op.a = sx(gap[2]); op.b = sx(gap[2]); op.dst = ACC_G; end
			5'd3:  begin op.a = sx(pv[0]); op.b = sx(pv[0]); op.dst = ACC_LP; end
			5'd4:  begin op.a = sx(pv[1]); op.b = sx(pv[1]); op.dst = ACC_LP; end
			5'd5:  begin op.a = sx(pv[2]); op.b = sx(pv[2]); op.dst = ACC_LP; end
			5'd6:  begin op.a = sx(item_q.cv[0]); op.b = sx(item_q.cv[0]); op.dst = ACC_LC; end
			5'd7:  begin op.a = sx(item_q.cv[1]); op.b = sx(item_q.cv[1]); op.dst = ACC_LC; end
			5'd8:  begin op.a = sx(item_q.cv[2]); op.b = sx(item_q.cv[2]); op.dst = ACC_LC; end
			5'd9:  begin op.a = sx(pv[0]); op.b = sx(item_q.cv[0]); op.dst = ACC_DOT; end
			5'd10: begin op.a = sx(pv[1]); op.b = sx(item_q.cv[1]); op.dst = ACC_DOT; end
			5'd11: begin op.a = sx(pv[2]); op.b = sx(item_q.cv[2]); op.dst = ACC_DOT; end
			5'd12: begin op.a = MUL_W'(eps); op.b = MUL_W'(eps); op.dst = ACC_E; end
			5'd13: begin op.a = MUL_W'(thr); op.b = MUL_W'(thr); op.dst = ACC_T; end
			5'd14: begin
				op.a = z34(lp_v[33:0]); op.b = z34(lc_v[33:0]); op.dst = ACC_M; op.sh = 2'd0;
			end
			5'd15: begin
				op.a = z34(lp_v[33:0]); op.b = z34(lc_v[67:34]); op.dst = ACC_M; op.sh = 2'd1;
			end
			5'd16: begin
				op.a = z34(lp_v[67:34]); op.b = z34(lc_v[33:0]); op.dst = ACC_M; op.sh = 2'd1;
			end
			5'd17: begin
				op.a = z34(lp_v[67:34]); op.b = z34(lc_v[67:34]); op.dst = ACC_M; op.sh = 2'd2;
			end
			5'd18: begin
				op.a = z34(dabs_v[33:0]); op.b = z34(dabs_v[33:0]); op.dst = ACC_L; op.sh = 2'd0;
			end
			5'd19: begin
				op.a = z34(dabs_v[33:0]); op.b = z34(dabs_v[67:34]); op.dst = ACC_L; op.sh = 2'd1;
			end
			5'd20: begin
				op.a = z34(dabs_v[67:34]); op.b = z34(dabs_v[33:0]); op.dst = ACC_L; op.sh = 2'd1;
			end
			5'd21: begin
				op.a = z34(dabs_v[67:34]); op.b = z34(dabs_v[67:34]); op.dst = ACC_L; op.sh = 2'd2;
			end
			5'd22: begin op.a = z34(m_v[33:0]); op.b = MUL_W'(t_v); op.dst = ACC_R; op.sh = 2'd0; end
			5'd23: begin op.a = z34(m_v[67:34]); op.b = MUL_W'(t_v); op.dst = ACC_R; op.sh = 2'd1; end
			5'd24: begin op.a = z34(m_v[101:68]); op.b = MUL_W'(t_v); op.dst = ACC_R; op.sh = 2'd2; end
			5'd25: begin op.a = z34(m_v[135:102]); op.b = MUL_W'(t_v); op.dst = ACC_R; op.sh = 2'd3; end
			default: begin op = '0; end
		endcase
		op.en = (state_q == S_CALC) && (step_q <= LAST_ISSUE);
	end

	// shared multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= op.en;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= $signed(op.a) * $signed(op.b);
		dst_s1 <= op.dst;
		sh_s1  <= op.sh;
	end

	// align the product to its limb
	assign base = ACC_W'(p_s1);
	always_comb begin
		case (sh_s1)
			2'd0:    addend = base;
			2'd1:    addend = base << 34;
			2'd2:    addend = base << 68;
			default: addend = base << 102;
		endcase
	end

	// accumulators, cleared as a segment is taken
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int k = 0; k < ACC_N; k++) begin
				acc_q[k] <= '0;
			end
		end else if (en_s1) begin
			acc_q[dst_s1] <= acc_q[dst_s1] + addend;
		end
	end

	// merge test on finished sums
	assign gap_ok  = $signed(acc_q[ACC_G]) <= $signed(acc_q[ACC_E]);
	assign nz      = (acc_q[ACC_LP] != '0) && (acc_q[ACC_LC] != '0);
	assign lhs     = {acc_q[ACC_L][139:0], 30'b0};
	assign merge_d = gap_ok && nz && (lhs >= acc_q[ACC_R]);

	// update decisions
	assign pop       = (state_q == S_IDLE) && avail;
	assign out_free  = !out_valid_q || merged.ready;
	assign decide_go = (state_q == S_DECIDE) && (merge_q || !pend_valid_q || out_free);
	assign emit_mid  = decide_go && !merge_q && pend_valid_q;
	assign take_new  = decide_go && !merge_q;
	assign ext_end   = decide_go && merge_q;
	assign emit_last = (state_q == S_LAST) && out_free;
	assign oc_inc    = next_count(out_cnt_q);
	assign oc_new    = emit_mid ? oc_inc : out_cnt_q;
	assign ic_inc    = next_count(in_cnt_q);
	assign ram_we    = decide_go;
	assign ram_wdata = oc_new;

	// sequencer and registered output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			merge_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			in_cnt_q     <= '0;
			out_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (avail) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (cand_d) begin
						step_q  <= '0;
						state_q <= S_CALC;
					end else begin
						merge_q <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_CALC: begin
					if (step_q == LAST_STEP) begin
						merge_q <= merge_d;
						state_q <= S_DECIDE;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_DECIDE: begin
					if (decide_go) begin
						in_cnt_q  <= ic_inc;
						out_cnt_q <= oc_new;
						if (take_new) begin
							pend_valid_q <= 1'b1;
						end
						state_q <= item_q.last ? S_LAST : S_IDLE;
					end
				end
				S_LAST: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						in_cnt_q     <= '0;
						out_cnt_q    <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit_mid || emit_last) begin
				out_valid_q <= 1'b1;
			end else if (merged.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// segment, pending and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= item;
		end
		if (state_q == S_READ) begin
			rp_q <= rp_d;
		end
		if (emit_mid || emit_last) begin
			out_s_q     <= pend_s_q;
			out_e_q     <= pend_e_q;
			out_sr_q    <= pend_sr_q;
			out_er_q    <= pend_er_q;
			out_depth_q <= pend_depth_q;
			out_par_q   <= pend_par_q;
			out_last_q  <= emit_last;
		end
		if (take_new) begin
			pend_s_q     <= item_q.s;
			pend_e_q     <= item_q.e;
			pend_sr_q    <= item_q.sr;
			pend_er_q    <= item_q.er;
			pend_depth_q <= item_q.depth;
			pend_par_q   <= rp_q;
		end else if (ext_end) begin
			pend_e_q  <= item_q.e;
			pend_er_q <= item_q.er;
		end
	end

	// merged segment request
	assign merged.valid            = out_valid_q;
	assign merged.out_start_x      = out_s_q[0];
	assign merged.out_start_y      = out_s_q[1];
	assign merged.out_start_z      = out_s_q[2];
	assign merged.out_end_x        = out_e_q[0];
	assign merged.out_end_y        = out_e_q[1];
	assign merged.out_end_z        = out_e_q[2];
	assign merged.out_start_radius = out_sr_q;
	assign merged.out_end_radius   = out_er_q;
	assign merged.out_depth        = out_depth_q;
	assign merged.out_parent       = out_par_q;
	assign merged.out_last         = out_last_q;

	// checks
	a_merge_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && merge_q) |-> pend_valid_q)
		else $error("merge decided without a pending segment");

	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_mid || emit_last) |-> out_free)
		else $error("output register overwritten while held");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_last |=> (!pend_valid_q && in_cnt_q == '0 && out_cnt_q == '0))
		else $error("final flush left state behind");

	a_pop_reads_table: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == S_READ))
		else $error("segment taken without a table read");

endmodule

// File: rtl/core/colinear_segment_merger.sv
// top level of the colinear segment merger: configuration registers, front end, queue, engine
// depends on csm_pkg, csm_if, csm_front, csm_queue, csm_back, csm_ram
//
//  channel   dir  handshake       payload
//  seg       in   valid / ready   segment endpoints, radii, depth, parent, final flag
//  merged    out  valid / ready   merged segment, remapped parent, last flag
//  cfg       in   cfg_we          cfg_index, cfg_wdata (no read-back)
//
// a segment with no merge candidate passes the idle, table read and decide states of the engine;
// a candidate also passes the calc state: the 26 products of the merge test issue one per cycle
// through the single shared 35x35 multiplier and are accumulated before the decide state
// the final segment adds the flush state; a held output register stalls the update
// reset clears the state, counts and valid bits and loads the default configuration; the remap table is left unwritten
// the two entry queue keeps taking segments while it has room, also while the engine works or the output stalls

module colinear_segment_merger #(
	parameter int MAX_SEGMENTS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [csm_pkg::EPS_W-1:0] cfg_wdata,
	csm_seg_if.sink                   seg,
	csm_merged_if.source              merged
);
	import csm_pkg::*;

	typedef enum logic [0:0] {REG_POSITION_EPSILON = 1'b0, REG_COS_THRESHOLD = 1'b1} cfg_reg_t;

	logic [EPS_W-1:0] eps_q;
	logic [THR_W-1:0] thr_q;
	seg_item_t        f_item;
	seg_item_t        q_item;
	logic             f_push;
	logic             q_room;
	logic             q_avail;
	logic             b_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_W'(66);
			thr_q <= THR_W'(32768);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POSITION_EPSILON: eps_q <= cfg_wdata;
				REG_COS_THRESHOLD:    thr_q <= cfg_wdata[THR_W-1:0];
				default:              eps_q <= eps_q;
			endcase
		end
	end

	csm_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
		.seg  (seg),
		.room (q_room),
		.push (f_push),
		.item (f_item)
	);

	csm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_item),
		.room   (q_room),
		.pop    (b_pop),
		.dout   (q_item),
		.avail  (q_avail)
	);

	csm_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (q_item),
		.avail  (q_avail),
		.pop    (b_pop),
		.eps    (eps_q),
		.thr    (thr_q),
		.merged (merged)
	);

endmodule

// File: dv/csm_tb_if.sv
`timescale 1ns / 1ps
// testbench view of the merger channels: no extra interfaces needed, reuses csm_seg_if and
// csm_merged_if from the rtl; this file holds the shared request record types, register
// indexes and the merge scoreboard; depends on csm_pkg

package csm_tb_pkg;
	import csm_pkg::*;

	// one merged segment as seen on the output channel
	typedef struct packed {
		logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
		logic [RAD_W-1:0]          sr, er;
		logic [DEPTH_W-1:0]        depth;
		logic signed [PAR_W-1:0]   parent;
		logic                      last;
	} merged_seg_t;

	// one input segment request
	typedef struct packed {
		logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
		logic [RAD_W-1:0]          sr, er;
		logic [DEPTH_W-1:0]        depth;
		logic signed [PAR_W-1:0]   parent;
		logic                      fin;
	} in_seg_t;

	// register indexes of the configuration port
	localparam logic [0:0] REG_EPSILON   = 1'b0;
	localparam logic [0:0] REG_THRESHOLD = 1'b1;

	localparam int NSEG = 1024;

	// merge predictor and expected-output store
	class merge_scoreboard;
		logic [EPS_W-1:0] eps;
		logic [THR_W-1:0] thr;
		bit               pend_valid;
		merged_seg_t      pend;
		int               in_cnt, out_cnt;
		int               remap [NSEG];
		merged_seg_t      expected_segs [$];
		int               errors;

		function new();
			eps = 66;
			thr = 32768;
			pend_valid = 0;
			in_cnt = 0;
			out_cnt = 0;
			errors = 0;
			foreach (remap[i]) remap[i] = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [EPS_W-1:0] v);
			if (idx == REG_EPSILON) eps = v;
			else thr = v[THR_W-1:0];
		endfunction

		// exact colinear and gap test against the pending segment
		function bit joins(in_seg_t s);
			logic signed [80:0] g [3], p [3], c [3];
			logic [79:0] gap2, lp, lc;
			logic signed [80:0] dt;
			logic [79:0] adt;
			logic [191:0] lhs, rhs;
			g[0] = s.sx - pend.ex; g[1] = s.sy - pend.ey; g[2] = s.sz - pend.ez;
			p[0] = pend.ex - pend.sx; p[1] = pend.ey - pend.sy; p[2] = pend.ez - pend.sz;
			c[0] = s.ex - s.sx; c[1] = s.ey - s.sy; c[2] = s.ez - s.sz;
			gap2 = 0; lp = 0; lc = 0; dt = 0;
			for (int k = 0; k < 3; k++) begin
				gap2 += 80'(g[k] * g[k]);
				lp += 80'(p[k] * p[k]);
				lc += 80'(c[k] * c[k]);
				dt += 81'(p[k] * c[k]);
			end
			if (gap2 > 80'(64'(eps) * 64'(eps))) return 0;
			if (lp == 0 || lc == 0) return 0;
			adt = dt < 0 ? 80'(-dt) : 80'(dt);
			lhs = (192'(adt) * 192'(adt)) << 30;
			rhs = 192'(lp) * 192'(lc) * 192'(32'(thr) * 32'(thr));
			return lhs >= rhs;
		endfunction

		function void note_input(in_seg_t s);
			int rp;
			bit mrg;
			rp = -1;
			if (s.parent >= 0 && s.parent < NSEG) rp = remap[s.parent];
			mrg = pend_valid && rp == out_cnt && joins(s);
			if (mrg) begin
				pend.ex = s.ex; pend.ey = s.ey; pend.ez = s.ez; pend.er = s.er;
			end else begin
				if (pend_valid) begin
					pend.last = 0;
					expected_segs.insert(expected_segs.size(), pend);
					out_cnt = (out_cnt + 1 >= NSEG) ? 0 : out_cnt + 1;
				end
				pend = '{s.sx, s.sy, s.sz, s.ex, s.ey, s.ez, s.sr, s.er, s.depth,
					PAR_W'(rp), 1'b0};
				pend_valid = 1;
			end
			remap[in_cnt] = out_cnt;
			in_cnt = (in_cnt + 1 >= NSEG) ? 0 : in_cnt + 1;
			if (s.fin) begin
				pend.last = 1;
				expected_segs.insert(expected_segs.size(), pend);
				pend_valid = 0;
				in_cnt = 0;
				out_cnt = 0;
				foreach (remap[i]) remap[i] = 0;
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_output(merged_seg_t got);
			merged_seg_t w;
			if (expected_segs.size() == 0) begin
				report("merged segment with none expected");
				return;
			end
			w = expected_segs.pop_front();
			if (got.sx !== w.sx || got.sy !== w.sy || got.sz !== w.sz)
				report($sformatf("start got %h %h %h exp %h %h %h",
					got.sx, got.sy, got.sz, w.sx, w.sy, w.sz));
			if (got.ex !== w.ex || got.ey !== w.ey || got.ez !== w.ez)
				report($sformatf("end got %h %h %h exp %h %h %h",
					got.ex, got.ey, got.ez, w.ex, w.ey, w.ez));
			if (got.sr !== w.sr) report($sformatf("start radius %h exp %h", got.sr, w.sr));
			if (got.er !== w.er) report($sformatf("end radius %h exp %h", got.er, w.er));
			if (got.depth !== w.depth) report($sformatf("depth %h exp %h", got.depth, w.depth));
			if (got.parent !== w.parent)
				report($sformatf("parent %0d exp %0d", got.parent, w.parent));
			if (got.last !== w.last) report($sformatf("last %b exp %b", got.last, w.last));
		endtask
	endclass
endpackage

// File: dv/tb_colinear_segment_merger.sv
`timescale 1ns / 1ps
// testbench of colinear_segment_merger: drives directed segments and skeleton segment streams with random gaps
// depends on csm_pkg, csm_if and csm_tb_pkg (dv/csm_tb_if.sv)

module tb_colinear_segment_merger;
	import csm_pkg::*;
	import csm_tb_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [0:0] cfg_index = REG_EPSILON;
	logic [EPS_W-1:0] cfg_wdata = 0;

	csm_seg_if seg ();
	csm_merged_if merged ();

	colinear_segment_merger dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .seg(seg.sink), .merged(merged.source)
	);

	merge_scoreboard sb;
	int cycles = 0;
	int hold_off = 0;
	int out_wait = 0;
	int rdy_draw;
	bit no_idle = 0;
	int seg_in_skel = 0;
	logic signed [31:0] cx, cy, cz;
	localparam int LIMIT = 400000;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		seg.valid = 0;
		{seg.start_x, seg.start_y, seg.start_z, seg.end_x, seg.end_y, seg.end_z} = '0;
		{seg.start_radius, seg.end_radius, seg.branch_depth, seg.parent_in, seg.final_in} = '0;
		merged.ready = 0;
		sb = new();
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output side: a drawn wait after each merged segment plus one long hold-off
	always @(posedge clk) begin
		if (arst_n && merged.valid && merged.ready)
			sb.check_output('{merged.out_start_x, merged.out_start_y, merged.out_start_z,
				merged.out_end_x, merged.out_end_y, merged.out_end_z, merged.out_start_radius,
				merged.out_end_radius, merged.out_depth, merged.out_parent, merged.out_last});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			merged.ready <= 0;
		end else if (arst_n && merged.valid && merged.ready) begin
			rdy_draw = no_idle ? 0 : $urandom_range(0, 6);
			out_wait <= rdy_draw;
			merged.ready <= (rdy_draw == 0);
		end else if (out_wait > 0) begin
			out_wait <= out_wait - 1;
			merged.ready <= (out_wait == 1);
		end else
			merged.ready <= 1;
	end

	task write_reg(logic [0:0] idx, logic [EPS_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, v);
	endtask

	task drain();
		seg.valid <= 0;
		while (sb.expected_segs.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// offer one segment and wait for it to be taken
	task send_seg(in_seg_t s);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			seg.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		seg.valid <= 1;
		{seg.start_x, seg.start_y, seg.start_z} <= {s.sx, s.sy, s.sz};
		{seg.end_x, seg.end_y, seg.end_z} <= {s.ex, s.ey, s.ez};
		seg.start_radius <= s.sr;
		seg.end_radius <= s.er;
		seg.branch_depth <= s.depth;
		seg.parent_in <= s.parent;
		seg.final_in <= s.fin;
		do @(posedge clk); while (!seg.ready);
		sb.note_input(s);
		seg_in_skel = s.fin ? 0 : seg_in_skel + 1;
	endtask

	function logic signed [10:0] pick_parent();
		int r;
		r = $urandom_range(0, 9);
		if (seg_in_skel == 0 || r == 0) return -11'sd1 - 11'($urandom_range(0, 1023));
		if (r == 1) return -11'sd1024;
		if (r < 6) return 11'(seg_in_skel - 1);
		return 11'($urandom_range(0, seg_in_skel - 1));
	endfunction

	// a segment that usually continues the chain: colinear with a small jitter
	function in_seg_t chain_seg(bit fin);
		in_seg_t s;
		int step;
		logic signed [31:0] j;
		step = $urandom_range(1, 1 << $urandom_range(0, 20));
		j = $urandom_range(0, 3) == 0 ? $signed(32'($urandom_range(0, 200))) - 100 : 0;
		s.sx = cx + j; s.sy = cy; s.sz = cz;
		s.ex = s.sx + step;
		s.ey = s.sy + ($urandom_range(0, 2) == 0 ? step / ($urandom_range(1, 64)) : 0);
		s.ez = s.sz + ($urandom_range(0, 5) == 0 ? $urandom_range(0, 9) : 0);
		if ($urandom_range(0, 15) == 0) s.ex = s.sx;
		if ($urandom_range(0, 15) == 0) begin s.ex = s.sx; s.ey = s.sy; s.ez = s.sz; end
		if ($urandom_range(0, 15) == 0) s.ex = s.sx - step;
		s.sr = 31'($urandom); s.er = 31'($urandom);
		s.depth = 8'($urandom);
		s.parent = pick_parent();
		if (seg_in_skel > 0 && $urandom_range(0, 9) < 6) s.parent = 11'(seg_in_skel - 1);
		s.fin = fin;
		cx = s.ex; cy = s.ey; cz = s.ez;
		return s;
	endfunction

	function in_seg_t noise_seg(bit fin);
		in_seg_t s;
		s = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 31'($urandom),
			31'($urandom), 8'($urandom), 11'sd0, fin};
		s.parent = pick_parent();
		return s;
	endfunction

	task run_skeleton(int n, bit noisy);
		cx = $urandom; cy = $urandom; cz = $urandom;
		for (int i = 0; i < n; i++)
			send_seg(noisy && $urandom_range(0, 4) == 0 ? noise_seg(i == n - 1)
				: chain_seg(i == n - 1));
	endtask

	initial begin
		in_seg_t d;
		#1;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// directed: extremes, exact colinear, gap edge, zero vectors, anti-parallel
		cx = 0; cy = 0; cz = 0;
		d = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 31'h7fffffff, 31'h0, 8'hff, -11'sd1, 1'b0};
		send_seg(d);
		d = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 31'h0, 31'h7fffffff, 8'h00, 11'sd0, 1'b0};
		send_seg(d);
		d = '{0, 0, 0, 100, 0, 0, 5, 6, 1, 11'sd1, 1'b0};
		send_seg(d);
		d = '{166, 0, 0, 300, 0, 0, 7, 8, 2, 11'sd2, 1'b0};
		send_seg(d);
		d = '{300, 0, 0, 100, 0, 0, 9, 9, 3, 11'sd3, 1'b0};
		send_seg(d);
		d = '{100, 0, 0, 100, 0, 0, 1, 1, 4, 11'sd4, 1'b0};
		send_seg(d);
		d = '{100, 0, 0, 200, 0, 0, 1, 1, 4, -11'sd1024, 1'b0};
		send_seg(d);
		d = '{267, 0, 0, 400, 0, 0, 2, 2, 5, 11'sd6, 1'b1};
		send_seg(d);
		d = '{0, 0, 0, 5, 5, 5, 3, 3, 6, -11'sd1, 1'b1};
		send_seg(d);
		drain();

		// random phases over register settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_EPSILON, 0); write_reg(REG_THRESHOLD, 0); end
				1: begin write_reg(REG_EPSILON, 31'h7fffffff); write_reg(REG_THRESHOLD, 16'hffff); end
				2: begin write_reg(REG_EPSILON, 200); write_reg(REG_THRESHOLD, 32768); end
				3: begin write_reg(REG_EPSILON, 31'h7fffffff); write_reg(REG_THRESHOLD, 32000); end
				4: begin
					write_reg(REG_EPSILON, 31'($urandom));
					write_reg(REG_THRESHOLD, 31'($urandom));
				end
				default: begin write_reg(REG_EPSILON, 66); write_reg(REG_THRESHOLD, 32768); end
			endcase
			no_idle = (ph == 3);
			if (ph == 2) hold_off = 400;
			for (int k = 0; k < 6; k++)
				run_skeleton($urandom_range(1, 30), k % 3 == 0);
			// sender pause until every merged segment is out
			drain();
		end

		// one skeleton longer than the table to wrap the counts
		write_reg(REG_EPSILON, 31'h7fffffff);
		write_reg(REG_THRESHOLD, 16'h0);
		run_skeleton(1100, 1);
		drain();

		if (sb.errors == 0 && sb.expected_segs.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
